>>> rtl/sde_pkg.sv
// Package with the beat types, mode codes and segment constants of the display encoder.
package sde_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegGaugeFull = 2'd0;
  localparam logic [CfgIdxW-1:0] RegGaugeMid  = 2'd1;

  // Fixed display codes.
  localparam logic [7:0] ModeBlank  = 8'h00;
  localparam logic [7:0] ModeAllOn  = 8'hFF;
  localparam logic [7:0] ModeTen    = 8'h10;
  localparam logic [7:0] ModeBar0F  = 8'h0F;
  localparam logic [7:0] ModeBar1F  = 8'h40;
  localparam logic [7:0] ModeBar3F  = 8'h80;
  localparam logic [7:0] ModeBar7F  = 8'hC0;

  // Flag bits of all other modes.
  localparam int unsigned FlagCharge  = 0;
  localparam int unsigned FlagGauge   = 1;
  localparam int unsigned FlagPercent = 2;
  localparam int unsigned FlagL1      = 3;

  localparam logic [7:0] SegBlank    = 8'h00;
  localparam logic [7:0] SegPercent  = 8'h80;
  localparam logic [7:0] IconHund    = 8'h06;
  localparam logic [7:0] IconL1      = 8'h01;
  localparam logic [7:0] IconCharge  = 8'h80;
  localparam logic [7:0] GaugeThree  = 8'h70;
  localparam logic [7:0] GaugeTwo    = 8'h30;
  localparam logic [7:0] GaugeOne    = 8'h10;

  typedef struct packed {
    logic [7:0]  mode;
    logic [7:0]  battery_percent;
    logic [15:0] elapsed_time;
  } sde_in_t;

  typedef struct packed {
    logic [7:0] tens_segments;
    logic [7:0] units_segments;
    logic [7:0] icon_segments;
  } sde_out_t;

  typedef struct packed {
    logic [CfgDataW-1:0] full_limit;
    logic [CfgDataW-1:0] mid_limit;
  } sde_limits_t;

  // Seven-segment font, bit0 segment A to bit6 segment G.
  function automatic logic [7:0] digit_font(input logic [3:0] digit);
    logic [7:0] seg;
    case (digit)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h6F;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

>>> rtl/sde_encode.sv
// Combinational encoder from one display request to the three segment bytes.
module sde_encode
  import sde_pkg::*;
(
  input  sde_in_t     item_i,
  input  sde_limits_t limits_i,
  output sde_out_t    result_o
);

  logic [6:0]  pct7;
  logic [14:0] pct_prod;
  logic [3:0]  tens_digit;
  logic [6:0]  tens_times_ten;
  logic [6:0]  units_wide;
  logic [3:0]  hi_digit;
  logic [3:0]  lo_digit;
  logic        pct_full;
  logic [7:0]  flag_tens;
  logic [7:0]  flag_units;
  logic [7:0]  flag_icon;
  logic [7:0]  gauge_icon;

  // Below 100 the percentage fits seven bits; 205/2048 approximates 1/10 exactly there.
  assign pct_full       = item_i.battery_percent >= 8'd100;
  assign pct7           = item_i.battery_percent[6:0];
  assign pct_prod       = 15'(pct7) * 15'd205;
  assign tens_digit     = pct_prod[14:11];
  assign tens_times_ten = 7'({tens_digit, 3'b000}) + 7'({tens_digit, 1'b0});
  assign units_wide     = pct7 - tens_times_ten;
  assign hi_digit       = pct_full ? 4'd0 : tens_digit;
  assign lo_digit       = pct_full ? 4'd0 : units_wide[3:0];

  always_comb begin
    if (item_i.elapsed_time < limits_i.full_limit) begin
      gauge_icon = GaugeThree;
    end else if (item_i.elapsed_time < limits_i.mid_limit) begin
      gauge_icon = GaugeTwo;
    end else begin
      gauge_icon = GaugeOne;
    end
  end

  always_comb begin
    flag_tens  = SegBlank;
    flag_units = SegBlank;
    flag_icon  = 8'h00;
    if (item_i.mode[FlagPercent]) begin
      flag_tens  = digit_font(hi_digit);
      flag_units = digit_font(lo_digit) | SegPercent;
      if (pct_full) begin
        flag_icon = flag_icon | IconHund;
      end
    end
    if (item_i.mode[FlagL1]) begin
      flag_icon = flag_icon | IconL1;
    end
    if (item_i.mode[FlagCharge]) begin
      flag_icon = flag_icon | IconCharge;
    end
    if (item_i.mode[FlagGauge]) begin
      flag_icon = flag_icon | gauge_icon;
    end
  end

  always_comb begin
    case (item_i.mode)
      ModeBlank: result_o = '{SegBlank, SegBlank, 8'h00};
      ModeAllOn: result_o = '{8'hFF, 8'hFF, 8'hFF};
      ModeTen:   result_o = '{digit_font(4'd1), digit_font(4'd0), 8'h00};
      ModeBar0F: result_o = '{SegBlank, SegBlank, 8'h0F};
      ModeBar1F: result_o = '{SegBlank, SegBlank, 8'h1F};
      ModeBar3F: result_o = '{SegBlank, SegBlank, 8'h3F};
      ModeBar7F: result_o = '{SegBlank, SegBlank, 8'h7F};
      default:   result_o = '{flag_tens, flag_units, flag_icon};
    endcase
  end

endmodule

>>> rtl/segment_display_encoder.sv
// Segment display encoder: display request in, tens, units and icon segment bytes out.
//
// The input channel carries one display request per beat (mode, battery percentage,
// elapsed time); the output channel carries one beat of three segment bytes for each
// request, in order. Both channels use valid and stall.
// A request is captured in an input register when accepted, encoded by combinational
// logic and written into the result register when free; that register drives the output.
// Throughput is one request per cycle while the receiver does not stall; the encode
// path between the two registers (a multiply by a constant for the tens digit and two
// 16-bit compares) sets the clock. When the receiver stalls, the result register holds
// its beat and the input register fills behind it; the input stalls only when both are
// occupied and the receiver stalls. The user must write the gauge limits through the
// configuration port only while the block is idle; the block itself does not enforce
// this. Reset clears both pipeline valid flags and sets both gauge limits to zero.
module segment_display_encoder
  import sde_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sde_in_t             in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sde_out_t            out_item_o
);

  sde_limits_t limits_q;
  sde_in_t     item_q;
  logic        item_valid_q;
  sde_out_t    result_d;
  sde_out_t    result_q;
  logic        result_valid_q;
  logic        result_free;
  logic        item_free;

  assign result_free = !result_valid_q || !out_stall_i;
  assign item_free   = !item_valid_q || result_free;
  assign in_stall_o  = !item_free;
  assign out_valid_o = result_valid_q;
  assign out_item_o  = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegGaugeFull: limits_q.full_limit <= cfg_wdata_i;
        RegGaugeMid:  limits_q.mid_limit  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q   <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      if (item_free) begin
        item_valid_q <= in_valid_i;
      end
      if (result_free) begin
        result_valid_q <= item_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_free && in_valid_i) begin
      item_q <= in_item_i;
    end
    if (result_free && item_valid_q) begin
      result_q <= result_d;
    end
  end

  sde_encode u_encode (
    .item_i   (item_q),
    .limits_i (limits_q),
    .result_o (result_d)
  );

endmodule
